@@ design/bevq_pkg.sv @@
// Package for the button event qualifier: commands, register indexes,
// configuration, item, counter-row and update types, and the pin activity helper.
// No dependencies; every other design file imports it.
package bevq_pkg;

  localparam int PIN_COUNT = 64;
  localparam int PIN_W = (PIN_COUNT > 2) ? $clog2(PIN_COUNT) : 1;
  localparam logic [11:0] CNT_MAX = 12'hFFF;

  typedef enum logic [2:0] {
    CMD_DEBOUNCE = 3'd0,
    CMD_LIMIT    = 3'd1,
    CMD_SHORT    = 3'd2,
    CMD_LONG     = 3'd3,
    CMD_REPEAT   = 3'd4,
    CMD_CHORD    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_DEBOUNCE_COUNT = 3'd0,
    REG_LIMIT_COUNT    = 3'd1,
    REG_LONG_PRESS     = 3'd2,
    REG_REPEAT_DELAY   = 3'd3,
    REG_REPEAT_INTVL   = 3'd4,
    REG_ACTIVE_HIGH    = 3'd5,
    REG_OVERRIDE       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  debounce_count;
    logic [7:0]  limit_count;
    logic [11:0] long_press_count;
    logic [9:0]  repeat_delay;
    logic [9:0]  repeat_interval;
    logic [63:0] active_high_mask;
    logic [63:0] override_mask;
  } cfg_t;

  typedef struct packed {
    cmd_t       command;
    logic [5:0] pin_index;
    logic       pin_level;
    logic [5:0] second_pin;
    logic       second_level;
  } item_t;

  // One memory row holds every counter bank entry of one pin.
  typedef struct packed {
    logic [11:0] chord;
    logic [11:0] rep;
    logic [11:0] long_press;
    logic [11:0] short_press;
    logic [7:0]  limit;
    logic [7:0]  deb;
  } row_t;

  typedef struct packed {
    logic wr_a;
    logic wr_b;
    row_t row_a;
    row_t row_b;
    logic asserted;
  } upd_t;

  function automatic logic pin_active(cfg_t c, logic [5:0] pin, logic level);
    return (level == c.active_high_mask[pin]) || c.override_mask[pin];
  endfunction

endpackage

@@ design/button_event_qualifier.sv @@
// Button event qualifier. Each accepted transaction is one sample tick of one pin and yields
// exactly one result transaction, registered in the compute stage, then in the output
// register when free. Commands 0 to 4 are taken one per cycle unless the output stalls; a
// chord blocks the next while writing back two counter rows through the single write port
// of the counter memory. All counter banks start at zero after reset through per-row valid
// bits, so no clearing pass is needed. While a result waits on out_tready, one more item is
// accepted into the compute stage and in_tready then stays low until the result is taken.
module button_event_qualifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] command, [8:3] pin_index, [9] pin_level, [15:10] second_pin,
  // [16] second_level, [23:17] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] asserted, [7:1] zero
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import bevq_pkg::*;

  cfg_t             cfg;
  item_t            in_item;
  logic             in_acc;
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  item_t            s1_item_r;
  logic             s1_go;
  row_t             mem_a;
  row_t             mem_b;
  row_t             row_a;
  upd_t             upd;
  logic             wr_en;
  logic [PIN_W-1:0] wr_addr;
  row_t             wr_row;
  logic             pend_valid_r;
  logic [PIN_W-1:0] pend_addr_r;
  row_t             pend_row_r;
  logic             fwd_valid_r;
  logic [PIN_W-1:0] fwd_addr_r;
  row_t             fwd_row_r;
  logic             out_valid_r;
  logic             out_asserted_r;

  bevq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_item.command      = cmd_t'(in_tdata[2:0]);
  assign in_item.pin_index    = in_tdata[8:3];
  assign in_item.pin_level    = in_tdata[9];
  assign in_item.second_pin   = in_tdata[15:10];
  assign in_item.second_level = in_tdata[16];

  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  // A chord leaving the compute stage needs the next cycle for its second write.
  assign in_tready = !s1_valid_r || (s1_go && (s1_item_r.command != CMD_CHORD));
  assign in_acc    = in_tvalid && in_tready;

  bevq_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_addr_a (in_item.pin_index[PIN_W-1:0]),
    .rd_addr_b (in_item.second_pin[PIN_W-1:0]),
    .rd_row_a  (mem_a),
    .rd_row_b  (mem_b),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_row    (wr_row)
  );

  // The last write may have landed in the same cycle as this item's read.
  assign row_a = (fwd_valid_r && (fwd_addr_r == s1_item_r.pin_index[PIN_W-1:0])) ?
                 fwd_row_r : mem_a;

  bevq_qual u_qual (
    .cfg   (cfg),
    .item  (s1_item_r),
    .row_a (row_a),
    .row_b ((fwd_valid_r && (fwd_addr_r == s1_item_r.second_pin[PIN_W-1:0])) ?
            fwd_row_r : mem_b),
    .upd   (upd)
  );

  assign wr_en   = pend_valid_r || (s1_go && upd.wr_a);
  assign wr_addr = pend_valid_r ? pend_addr_r : s1_item_r.pin_index[PIN_W-1:0];
  assign wr_row  = pend_valid_r ? pend_row_r : upd.row_a;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      fwd_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      pend_valid_r <= s1_go && upd.wr_b;
      if (wr_en) begin
        fwd_valid_r <= 1'b1;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      pend_addr_r    <= s1_item_r.second_pin[PIN_W-1:0];
      pend_row_r     <= upd.row_b;
      out_asserted_r <= upd.asserted;
    end
    if (wr_en) begin
      fwd_addr_r <= wr_addr;
      fwd_row_r  <= wr_row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_asserted_r};

`ifndef SYNTHESIS
  a_pend_alone : assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !s1_valid_r)
    else $error("second chord write overlaps a busy compute stage");

  a_chord_interlock : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && s1_valid_r) |-> (s1_item_r.command != CMD_CHORD))
    else $error("item accepted behind a departing chord");

  a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("stalled compute stage lost its item");
`endif

endmodule

@@ design/bevq_cfg.sv @@
// Configuration register file for the button event qualifier.
// Depends on bevq_pkg for the register index codes and cfg_t.
module bevq_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output bevq_pkg::cfg_t    cfg
);
  import bevq_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_count       <= 8'd5;
      cfg_r.limit_count          <= 8'd5;
      cfg_r.long_press_count     <= 12'd100;
      cfg_r.repeat_delay         <= 10'd50;
      cfg_r.repeat_interval      <= 10'd10;
      cfg_r.active_high_mask     <= '0;
      cfg_r.override_mask        <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE_COUNT: cfg_r.debounce_count       <= cfg_data[7:0];
        REG_LIMIT_COUNT:    cfg_r.limit_count          <= cfg_data[7:0];
        REG_LONG_PRESS:     cfg_r.long_press_count     <= cfg_data[11:0];
        REG_REPEAT_DELAY:   cfg_r.repeat_delay         <= cfg_data[9:0];
        REG_REPEAT_INTVL:   cfg_r.repeat_interval      <= cfg_data[9:0];
        REG_ACTIVE_HIGH:    cfg_r.active_high_mask     <= cfg_data;
        REG_OVERRIDE:       cfg_r.override_mask        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/bevq_mem.sv @@
// Per-pin counter memory: one write port, two registered read ports,
// and a valid bit per row so that rows read as zero until first written.
// Depends on bevq_pkg for row_t and the pin count.
module bevq_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [bevq_pkg::PIN_W-1:0]  rd_addr_a,
  input  logic [bevq_pkg::PIN_W-1:0]  rd_addr_b,
  output bevq_pkg::row_t              rd_row_a,
  output bevq_pkg::row_t              rd_row_b,
  input  logic                        wr_en,
  input  logic [bevq_pkg::PIN_W-1:0]  wr_addr,
  input  bevq_pkg::row_t              wr_row
);
  import bevq_pkg::*;

  row_t                 mem_r [PIN_COUNT];
  logic [PIN_COUNT-1:0] vld_r;
  row_t                 rd_a_r;
  row_t                 rd_b_r;
  logic                 rv_a_r;
  logic                 rv_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_a_r <= mem_r[rd_addr_a];
      rd_b_r <= mem_r[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rv_a_r <= 1'b0;
      rv_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rv_a_r <= vld_r[rd_addr_a];
        rv_b_r <= vld_r[rd_addr_b];
      end
    end
  end

  assign rd_row_a = rv_a_r ? rd_a_r : '0;
  assign rd_row_b = rv_b_r ? rd_b_r : '0;

endmodule

@@ design/bevq_qual.sv @@
// Qualifier arithmetic: takes the current counter rows of the sampled pins
// and produces the updated rows, the write requests and the result bit.
// Depends on bevq_pkg for cfg_t, item_t, row_t and upd_t.
module bevq_qual (
  input  bevq_pkg::cfg_t  cfg,
  input  bevq_pkg::item_t item,
  input  bevq_pkg::row_t  row_a,
  input  bevq_pkg::row_t  row_b,
  output bevq_pkg::upd_t  upd
);
  import bevq_pkg::*;

  logic        pa_ok;
  logic        pb_ok;
  logic        same_pin;
  logic        on_a;
  logic        on_b;
  logic        on_p;
  logic [11:0] lp;
  logic [11:0] dc12;
  logic [11:0] plim;
  logic [11:0] base;
  logic [11:0] top;
  logic [11:0] rep_start;
  logic [11:0] ch_a;
  logic [11:0] ch_b_in;
  logic [11:0] ch_b;
  logic [11:0] ch_a_fin;
  row_t        new_a;
  row_t        new_b;
  logic        wr_a;
  logic        wr_b;
  logic        res;

  assign pa_ok    = {1'b0, item.pin_index} < 7'(PIN_COUNT);
  assign pb_ok    = {1'b0, item.second_pin} < 7'(PIN_COUNT);
  assign same_pin = item.pin_index == item.second_pin;
  assign on_a     = pin_active(cfg, item.pin_index, item.pin_level);
  assign on_b     = pin_active(cfg, item.second_pin, item.second_level);
  // A second pin of zero, or one beyond the pin range, never inhibits a press.
  assign on_p     = on_a && !((item.second_pin != '0) && pb_ok && on_b);

  assign lp        = cfg.long_press_count;
  assign dc12      = {4'b0, cfg.debounce_count};
  assign plim      = (lp == CNT_MAX) ? CNT_MAX : lp + 12'd1;
  assign base      = dc12 + {2'b0, cfg.repeat_delay};
  assign top       = base + {2'b0, cfg.repeat_interval};
  assign rep_start = (row_a.rep == top) ? base : row_a.rep;

  // Chord: the first pin counts while twice its count is below the long-press
  // count; the second pin then counts while one more stays below it.
  assign ch_a     = !on_a ? '0 :
                    ({row_a.chord, 1'b0} < {1'b0, lp}) ? row_a.chord + 12'd1 : row_a.chord;
  assign ch_b_in  = same_pin ? ch_a : row_b.chord;
  assign ch_b     = !on_b ? '0 :
                    ({1'b0, ch_b_in} + 13'd1 < {1'b0, lp}) ? ch_b_in + 12'd1 : ch_b_in;
  assign ch_a_fin = same_pin ? ch_b : ch_a;

  always_comb begin
    new_a = row_a;
    new_b = same_pin ? row_a : row_b;
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    res   = 1'b0;
    case (item.command)
      CMD_DEBOUNCE: begin
        if (!on_a) begin
          new_a.deb = '0;
        end else if (row_a.deb < cfg.debounce_count) begin
          new_a.deb = row_a.deb + 8'd1;
        end
        res  = new_a.deb == cfg.debounce_count;
        wr_a = 1'b1;
      end
      CMD_LIMIT: begin
        if (!on_a) begin
          new_a.limit = '0;
        end else if (row_a.limit < cfg.limit_count) begin
          new_a.limit = row_a.limit + 8'd1;
        end
        res  = new_a.limit == cfg.limit_count;
        wr_a = 1'b1;
      end
      CMD_SHORT: begin
        if (on_p) begin
          if (row_a.short_press < plim) begin
            new_a.short_press = row_a.short_press + 12'd1;
          end
        end else begin
          res = (row_a.short_press > dc12) && (row_a.short_press < lp);
          new_a.short_press = '0;
        end
        wr_a = 1'b1;
      end
      CMD_LONG: begin
        if (!on_p) begin
          new_a.long_press = '0;
        end else if (row_a.long_press < plim) begin
          new_a.long_press = row_a.long_press + 12'd1;
        end
        res  = new_a.long_press == lp;
        wr_a = 1'b1;
      end
      CMD_REPEAT: begin
        if (!on_a) begin
          new_a.rep = '0;
        end else if (rep_start < CNT_MAX) begin
          new_a.rep = rep_start + 12'd1;
        end else begin
          new_a.rep = rep_start;
        end
        res  = (new_a.rep == dc12) || (new_a.rep == top);
        wr_a = 1'b1;
      end
      CMD_CHORD: begin
        new_a.chord = ch_a;
        new_b.chord = ch_b;
        res  = ({ch_a_fin, 1'b0} >= {1'b0, lp}) && ({ch_b, 1'b0} >= {1'b0, lp});
        wr_a = pb_ok;
        wr_b = pb_ok;
        res  = res && pb_ok;
      end
      default: ;
    endcase
  end

  assign upd.wr_a     = wr_a && pa_ok;
  assign upd.wr_b     = wr_b && pa_ok;
  assign upd.row_a    = new_a;
  assign upd.row_b    = new_b;
  assign upd.asserted = res && pa_ok;

endmodule
